FILE: rtl/core/dlrq_pkg.sv
// Package: shared types, codes and field widths of the reachability query engine.
package dlrq_pkg;

    localparam int unsigned NODE_W  = 10;
    localparam int unsigned END_W   = 11;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned FIELD_LIMIT = 1024;

    typedef enum logic [1:0] {
        OP_LABEL = 2'd0,
        OP_LINK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        FB_NONE = 2'd0,
        FB_SAME = 2'd1,
        FB_TREE = 2'd2,
        FB_LINK = 2'd3
    } t_found;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LABEL,
        S_SCAN,
        S_DONE
    } t_state;

    // One transitive link entry: source preorder i, target interval [j,k)
    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] low;
        logic [END_W-1:0]  high;
    } t_link;

endpackage

FILE: rtl/core/dlrq_if.sv
// Interfaces: input item channel and result item channel with valid/ready handshake.
interface dlrq_in_if;
    import dlrq_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
    logic [NODE_W-1:0] preorder_value;
    logic [END_W-1:0]  interval_end;
    logic [NODE_W-1:0] link_slot;
    logic [NODE_W-1:0] link_source;
    logic [NODE_W-1:0] link_low;
    logic [END_W-1:0]  link_high;

    modport source (
        output valid, op, source_node, target_node, preorder_value, interval_end,
               link_slot, link_source, link_low, link_high,
        input  ready
    );
    modport sink (
        input  valid, op, source_node, target_node, preorder_value, interval_end,
               link_slot, link_source, link_low, link_high,
        output ready
    );
endinterface

interface dlrq_out_if;
    logic       valid;
    logic       ready;
    logic       reachable;
    logic [1:0] found_by;

    modport source (output valid, reachable, found_by, input ready);
    modport sink   (input valid, reachable, found_by, output ready);
endinterface

FILE: rtl/core/dlrq_node_mem.sv
// Node label memory: preorder number and subtree end per node, one write and two read ports.
module dlrq_node_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [dlrq_pkg::NODE_W-1:0] i_wpre,
    input  logic [dlrq_pkg::END_W-1:0]  i_wend,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [dlrq_pkg::NODE_W-1:0] o_pre_a,
    output logic [dlrq_pkg::END_W-1:0]  o_end_a,
    output logic [dlrq_pkg::NODE_W-1:0] o_pre_b
);
    import dlrq_pkg::*;

    logic [NODE_W-1:0] r_pre_mem [DEPTH];
    logic [END_W-1:0]  r_end_mem [DEPTH];
    logic [NODE_W-1:0] r_pre_a;
    logic [END_W-1:0]  r_end_a;
    logic [NODE_W-1:0] r_pre_b;

    // Store a node's labels
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pre_mem[i_waddr] <= i_wpre;
            r_end_mem[i_waddr] <= i_wend;
        end
    end

    // Read origin labels and destination preorder into registers
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_pre_a <= r_pre_mem[i_raddr_a];
            r_end_a <= r_end_mem[i_raddr_a];
            r_pre_b <= r_pre_mem[i_raddr_b];
        end
    end

    assign o_pre_a = r_pre_a;
    assign o_end_a = r_end_a;
    assign o_pre_b = r_pre_b;

endmodule

FILE: rtl/core/dlrq_link_mem.sv
// Link table memory: one write port and one registered read port.
module dlrq_link_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dlrq_pkg::t_link i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output dlrq_pkg::t_link o_rdata
);
    import dlrq_pkg::*;

    t_link r_mem [DEPTH];
    t_link r_rdata;

    // Store one link entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one entry per cycle for the scan
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/dual_label_reachability_query.sv
// Reachability query engine over a dual-labeling index held in two on-chip memories.
// Write items (node label, link entry) are taken back to back and give no result. A query
// (u,v) reads the node label memory once, then decides: a same node or tree interval hit,
// or a zero link count, ends it there, and the result register loads from the done state
// before the engine takes the next item.
// Otherwise the link memory is scanned from slot 0, one entry per cycle through its single
// read port, stopping at the first matching link; a full miss reads all n entries, with
// n = min(link_count, link table depth), so up to 1024 entries at the default sizes. A
// finished query waits while the result register still holds a result the sink has not
// taken, which stalls the input. A new item is taken only once the engine is idle; the
// result register holds the last result until the sink takes it. Memory contents are
// undefined after reset and need no clearing pass: software must load every label and
// link it later queries, and the block has no check for that.
module dual_label_reachability_query #(
    parameter int unsigned MAX_NODES = 1024,
    parameter int unsigned MAX_LINKS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dlrq_pkg::COUNT_W-1:0] i_cfg_wdata,
    dlrq_in_if.sink                      i_in,
    dlrq_out_if.source                   o_out
);
    import dlrq_pkg::*;

    // Field widths cap the addressable entries at FIELD_LIMIT
    localparam int unsigned NODE_DEPTH = (MAX_NODES < FIELD_LIMIT) ? MAX_NODES : FIELD_LIMIT;
    localparam int unsigned LINK_DEPTH = (MAX_LINKS < FIELD_LIMIT) ? MAX_LINKS : FIELD_LIMIT;
    localparam int unsigned NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int unsigned LAW = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] LINK_CAP = COUNT_W'(LINK_DEPTH);

    t_state            r_state, n_state;
    logic [COUNT_W-1:0] r_link_count;
    logic [COUNT_W-1:0] r_scan_idx, n_scan_idx;
    logic [COUNT_W-1:0] r_scan_n;
    logic              r_same;
    logic              r_u_ok;
    logic              r_v_ok;
    logic [NODE_W-1:0] r_a, n_a;
    logic [END_W-1:0]  r_b, n_b;
    logic [NODE_W-1:0] r_c, n_c;
    t_found            r_found, n_found;
    logic              r_out_valid;
    logic              r_reachable;
    t_found            r_found_by;

    logic              in_accept;
    logic              query_accept;
    logic              u_in_range;
    logic              slot_in_range;
    logic              node_we;
    logic              link_we;
    logic              out_load;
    logic              in_ready;
    logic [COUNT_W-1:0] scan_n;
    logic [COUNT_W-1:0] scan_next;
    logic [LAW-1:0]    link_raddr;
    logic              tree_hit;
    logic              link_hit;
    logic              scan_last;
    logic [NODE_W-1:0] pre_a;
    logic [END_W-1:0]  end_a;
    logic [NODE_W-1:0] pre_b;
    t_link             link_wdata;
    t_link             link_rdata;

    assign in_accept     = i_in.valid && in_ready;
    assign query_accept  = in_accept && (t_op'(i_in.op) == OP_QUERY);
    assign u_in_range    = int'(i_in.source_node) < int'(NODE_DEPTH);
    assign slot_in_range = int'(i_in.link_slot) < int'(LINK_DEPTH);
    assign scan_n        = (r_link_count < LINK_CAP) ? r_link_count : LINK_CAP;
    assign scan_next     = r_scan_idx + COUNT_W'(1);
    assign scan_last     = (scan_next == r_scan_n);

    assign link_wdata.src  = i_in.link_source;
    assign link_wdata.low  = i_in.link_low;
    assign link_wdata.high = i_in.link_high;

    dlrq_node_mem #(
        .DEPTH (NODE_DEPTH),
        .AW    (NAW)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_we      (node_we),
        .i_waddr   (i_in.source_node[NAW-1:0]),
        .i_wpre    (i_in.preorder_value),
        .i_wend    (i_in.interval_end),
        .i_re      (query_accept),
        .i_raddr_a (i_in.source_node[NAW-1:0]),
        .i_raddr_b (i_in.target_node[NAW-1:0]),
        .o_pre_a   (pre_a),
        .o_end_a   (end_a),
        .o_pre_b   (pre_b)
    );

    dlrq_link_mem #(
        .DEPTH (LINK_DEPTH),
        .AW    (LAW)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (i_in.link_slot[LAW-1:0]),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Hold the link count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_count <= '0;
        end else if (i_cfg_we) begin
            r_link_count <= i_cfg_wdata;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (query_accept) begin
                    n_state = S_LABEL;
                end
            end
            S_LABEL: begin
                if (r_same || tree_hit || (scan_n == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (link_hit || scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: handshake, memory strobes, scan address
    always_comb begin
        in_ready   = 1'b0;
        node_we    = 1'b0;
        link_we    = 1'b0;
        out_load   = 1'b0;
        link_raddr = '0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                node_we  = i_in.valid && (t_op'(i_in.op) == OP_LABEL) && u_in_range;
                link_we  = i_in.valid && (t_op'(i_in.op) == OP_LINK) && slot_in_range;
            end
            S_LABEL: begin
                link_raddr = '0;
            end
            S_SCAN: begin
                link_raddr = scan_next[LAW-1:0];
            end
            S_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Resolve labels, zero for nodes beyond the table
    always_comb begin
        n_a = r_u_ok ? pre_a : '0;
        n_b = r_u_ok ? end_a : '0;
        n_c = r_v_ok ? pre_b : '0;
    end

    assign tree_hit = (n_a <= n_c) && ({1'b0, n_c} < n_b);
    assign link_hit = (r_a <= link_rdata.src) && ({1'b0, link_rdata.src} < r_b) &&
                      (link_rdata.low <= r_c) && ({1'b0, r_c} < link_rdata.high);

    // Decide the answer and advance the scan index
    always_comb begin
        n_found    = r_found;
        n_scan_idx = r_scan_idx;
        case (r_state)
            S_LABEL: begin
                n_scan_idx = '0;
                if (r_same) begin
                    n_found = FB_SAME;
                end else if (tree_hit) begin
                    n_found = FB_TREE;
                end else begin
                    n_found = FB_NONE;
                end
            end
            S_SCAN: begin
                n_scan_idx = scan_next;
                if (link_hit) begin
                    n_found = FB_LINK;
                end
            end
            default: begin
                n_found = r_found;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query payload registers
    always_ff @(posedge i_clk) begin
        if (query_accept) begin
            r_same <= (i_in.source_node == i_in.target_node);
            r_u_ok <= u_in_range;
            r_v_ok <= int'(i_in.target_node) < int'(NODE_DEPTH);
        end
        if (r_state == S_LABEL) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_c      <= n_c;
            r_scan_n <= scan_n;
        end
        r_found    <= n_found;
        r_scan_idx <= n_scan_idx;
        if (out_load) begin
            r_reachable <= (r_found != FB_NONE);
            r_found_by  <= r_found;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.reachable = r_reachable;
    assign o_out.found_by  = r_found_by;

    // A query leaves idle for the label read
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_accept |=> (r_state == S_LABEL))
        else $error("query accepted but label read not started");

    // The scan never runs past the link count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx < r_scan_n))
        else $error("link scan index beyond link count");

    // Reachable flag agrees with the reason code
    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_reachable == (r_found_by != FB_NONE)))
        else $error("reachable flag disagrees with found_by");

    // Write items never produce a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !query_accept && !r_out_valid) |=> !r_out_valid)
        else $error("result produced by a write item");

endmodule

FILE: test/dual_label_reachability_query_test.sv
// Testbench for the reachability query engine: loads labels and links, predicts each answer.
module dual_label_reachability_query_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dlrq_pkg::*;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned NODE_MAX = 1023;
    localparam int unsigned END_MAX = 2047;
    localparam int unsigned PRE_SPAN = 63;
    localparam longint unsigned CYCLE_LIMIT = 6_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned HOLD_SPACING = 250;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned NUM_PHASES = 7;

    // Link counts per phase (extremes included) and the number of items in each phase
    localparam int unsigned PHASE_LINKS [NUM_PHASES] = '{3, 8, 0, 32, 1024, 2047, 5};
    localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{60, 110, 50, 150, 40, 35, 135};

    typedef struct {
        t_op               op;
        logic [NODE_W-1:0] src, dst, pre;
        logic [END_W-1:0]  iend;
        logic [NODE_W-1:0] slot, lsrc, llow;
        logic [END_W-1:0]  lhigh;
    } t_item;

    typedef struct {
        logic   reachable;
        t_found found_by;
    } t_answer;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    dlrq_in_if  in_ch ();
    dlrq_out_if out_ch ();

    dual_label_reachability_query dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor copy of the index and of the link count
    logic [NODE_W-1:0] pre_mirror  [TABLE_DEPTH];
    logic [END_W-1:0]  end_mirror  [TABLE_DEPTH];
    t_link             link_mirror [TABLE_DEPTH];
    int unsigned       count_mirror;

    // Stimulus bookkeeping: which labels and link slots have been loaded so far
    bit          node_known [TABLE_DEPTH];
    int unsigned known_nodes [$];
    bit          slot_known [TABLE_DEPTH];
    int unsigned slots_filled;

    t_item   items_to_send [$];
    t_answer answers_due [$];
    t_item   sent_item;

    int unsigned     fail_count;
    int unsigned     results_seen;
    int unsigned     next_hold_at;
    int unsigned     hold_left;
    int unsigned     burst_left;
    int unsigned     gap_left;
    int unsigned     stall_left;
    int unsigned     stall_mode;
    longint unsigned cycle_count;

    // Work out the answer to one query from the mirrored index
    function automatic t_answer reach_answer(input t_item it);
        t_answer     ans;
        int unsigned a, b, c, n, li, lj, lk;
        ans.found_by = FB_NONE;
        if (it.src == it.dst) begin
            ans.found_by = FB_SAME;
        end else begin
            c = 32'(pre_mirror[it.dst]);
            a = 32'(pre_mirror[it.src]);
            b = 32'(end_mirror[it.src]);
            if (a <= c && c < b) begin
                ans.found_by = FB_TREE;
            end else begin
                n = (count_mirror < TABLE_DEPTH) ? count_mirror : TABLE_DEPTH;
                for (int unsigned s = 0; s < n; s++) begin
                    li = 32'(link_mirror[s].src);
                    lj = 32'(link_mirror[s].low);
                    lk = 32'(link_mirror[s].high);
                    if (a <= li && li < b && lj <= c && c < lk) begin
                        ans.found_by = FB_LINK;
                        break;
                    end
                end
            end
        end
        ans.reachable = (ans.found_by != FB_NONE);
        return ans;
    endfunction

    function automatic t_item mk(input t_op op, input int unsigned src, dst, pre, iend,
                                 slot, lsrc, llow, lhigh);
        t_item it;
        it.op    = op;
        it.src   = NODE_W'(src);
        it.dst   = NODE_W'(dst);
        it.pre   = NODE_W'(pre);
        it.iend  = END_W'(iend);
        it.slot  = NODE_W'(slot);
        it.lsrc  = NODE_W'(lsrc);
        it.llow  = NODE_W'(llow);
        it.lhigh = END_W'(lhigh);
        return it;
    endfunction

    // Random item: mostly a tightly packed index so that intervals and links overlap,
    // with some full-range noise. Queries only touch labels that were loaded.
    function automatic t_item random_item(input t_op op);
        t_item it;
        it = mk(op, $urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX),
                $urandom_range(0, NODE_MAX), $urandom_range(0, END_MAX),
                $urandom_range(0, NODE_MAX), $urandom_range(0, NODE_MAX),
                $urandom_range(0, NODE_MAX), $urandom_range(0, END_MAX));
        case (op)
            OP_LABEL: begin
                if ($urandom_range(0, 9) != 0) begin
                    it.pre  = NODE_W'($urandom_range(0, PRE_SPAN));
                    it.iend = END_W'(32'(it.pre) + $urandom_range(0, 24));
                end
            end
            OP_LINK: begin
                if (slots_filled != 0 && $urandom_range(0, 3) != 0)
                    it.slot = NODE_W'($urandom_range(0, slots_filled - 1));
                if ($urandom_range(0, 9) != 0) begin
                    it.lsrc  = NODE_W'($urandom_range(0, PRE_SPAN));
                    it.llow  = NODE_W'($urandom_range(0, PRE_SPAN));
                    it.lhigh = END_W'(32'(it.llow) + $urandom_range(0, 16));
                end
            end
            OP_QUERY: begin
                if (known_nodes.size() == 0 || $urandom_range(0, 9) == 0) begin
                    it.dst = it.src;
                end else begin
                    it.src = NODE_W'(known_nodes[$urandom_range(0, known_nodes.size() - 1)]);
                    it.dst = NODE_W'(known_nodes[$urandom_range(0, known_nodes.size() - 1)]);
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic queue_item(input t_item it);
        if (it.op == OP_LABEL && !node_known[it.src]) begin
            node_known[it.src] = 1'b1;
            known_nodes = {known_nodes, 32'(it.src)};
        end
        if (it.op == OP_LINK) begin
            slot_known[it.slot] = 1'b1;
            while (slots_filled < TABLE_DEPTH && slot_known[slots_filled])
                slots_filled++;
        end
        items_to_send = {items_to_send, it};
    endtask

    // Block until every item went in and every answer came out
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_to_send.size() != 0 || in_ch.valid || answers_due.size() != 0);
    endtask

    task automatic write_link_count(input int unsigned value);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= COUNT_W'(value);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_mirror = value;
    endtask

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("error at %0t: %s", $realtime, what);
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive items in bursts with random gaps; update the mirror on each accepted item
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                case (sent_item.op)
                    OP_LABEL: begin
                        pre_mirror[sent_item.src] = sent_item.pre;
                        end_mirror[sent_item.src] = sent_item.iend;
                    end
                    OP_LINK: begin
                        link_mirror[sent_item.slot] =
                            '{sent_item.lsrc, sent_item.llow, sent_item.lhigh};
                    end
                    OP_QUERY: answers_due = {answers_due, reach_answer(sent_item)};
                    default: ;
                endcase
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    sent_item = items_to_send.pop_front();
                    in_ch.op             <= sent_item.op;
                    in_ch.source_node    <= sent_item.src;
                    in_ch.target_node    <= sent_item.dst;
                    in_ch.preorder_value <= sent_item.pre;
                    in_ch.interval_end   <= sent_item.iend;
                    in_ch.link_slot      <= sent_item.slot;
                    in_ch.link_source    <= sent_item.lsrc;
                    in_ch.link_low       <= sent_item.llow;
                    in_ch.link_high      <= sent_item.lhigh;
                    in_ch.valid          <= 1'b1;
                    if (burst_left <= 1) begin
                        if ($urandom_range(0, 7) == 0) begin
                            burst_left = 60;
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 16);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Hold the result channel off for a long stretch every so often
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end
    end

    // Check each result against the oldest answer due; stall in changing modes
    always @(posedge clk) begin
        t_answer want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen <= results_seen + 1;
                if (answers_due.size() == 0) begin
                    report_failure($sformatf("result (reachable %0b, found_by %0d) with no query",
                                             out_ch.reachable, out_ch.found_by));
                end else begin
                    want = answers_due.pop_front();
                    if (out_ch.reachable !== want.reachable)
                        report_failure($sformatf("reachable: expected %0b, got %0b",
                                                 want.reachable, out_ch.reachable));
                    if (out_ch.found_by !== want.found_by)
                        report_failure($sformatf("found_by: expected %0d, got %0d",
                                                 want.found_by, out_ch.found_by));
                end
            end
            if (cycle_count[8:0] == '0)
                stall_mode = $urandom_range(0, 2);
            if (stall_left != 0) begin
                stall_left--;
            end else if (stall_mode == 1) begin
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 4);
            end else if (stall_mode == 2) begin
                if ($urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 20);
            end
            out_ch.ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    // Stimulus: directed checks, then random phases at different link counts
    initial begin
        t_item       it;
        t_op         op;
        int unsigned fill_to, done_items, pick;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.op             = OP_NOP;
        in_ch.source_node    = '0;
        in_ch.target_node    = '0;
        in_ch.preorder_value = '0;
        in_ch.interval_end   = '0;
        in_ch.link_slot      = '0;
        in_ch.link_source    = '0;
        in_ch.link_low       = '0;
        in_ch.link_high      = '0;
        out_ch.ready = 1'b0;
        count_mirror = 0;
        slots_filled = 0;
        fail_count   = 0;
        results_seen = 0;
        next_hold_at = 30;
        hold_left    = 0;
        burst_left   = 1;
        gap_left     = 0;
        stall_left   = 0;
        stall_mode   = 0;
        cycle_count  = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pre_mirror[i]  = '0;
            end_mirror[i]  = '0;
            link_mirror[i] = '0;
            node_known[i]  = 1'b0;
            slot_known[i]  = 1'b0;
        end

        // Labels at the field extremes, an empty and an inverted interval
        queue_item(mk(OP_LABEL, 0, 0, 0, 1024, 0, 0, 0, 0));
        queue_item(mk(OP_LABEL, NODE_MAX, 0, NODE_MAX, END_MAX, 0, 0, 0, 0));
        queue_item(mk(OP_LABEL, 5, 0, 10, 10, 0, 0, 0, 0));
        queue_item(mk(OP_LABEL, 6, 0, 20, 15, 0, 0, 0, 0));
        queue_item(mk(OP_LABEL, 7, 0, 12, 13, 0, 0, 0, 0));
        queue_item(mk(OP_LABEL, 682, 0, 341, 0, 0, 0, 0, 0));
        queue_item(mk(OP_LINK, 0, 0, 0, 0, 0, 12, NODE_MAX, END_MAX));
        queue_item(mk(OP_LINK, 0, 0, 0, 0, NODE_MAX, NODE_MAX, 0, 0));
        queue_item(mk(OP_LINK, 0, 0, 0, 0, 341, 0, 682, 1024));
        queue_item(mk(OP_NOP, NODE_MAX, NODE_MAX, NODE_MAX, END_MAX, NODE_MAX, NODE_MAX,
                      NODE_MAX, END_MAX));
        // Same node (also one never labeled), tree hits and misses with no links
        queue_item(mk(OP_QUERY, 512, 512, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, NODE_MAX, NODE_MAX, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 0, NODE_MAX, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, NODE_MAX, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 5, 7, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 6, 7, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 0, 682, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 7, NODE_MAX, 0, 0, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // One link: a link hit, and a scan from an empty interval
        write_link_count(1);
        queue_item(mk(OP_QUERY, 7, NODE_MAX, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUERY, 682, 0, 0, 0, 0, 0, 0, 0));

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_link_count(PHASE_LINKS[p]);
            // load every slot that the scan can reach before any query
            fill_to = (PHASE_LINKS[p] < TABLE_DEPTH) ? PHASE_LINKS[p] : TABLE_DEPTH;
            while (slots_filled < fill_to) begin
                it = random_item(OP_LINK);
                it.slot = NODE_W'(slots_filled);
                queue_item(it);
            end
            done_items = 0;
            while (done_items < PHASE_ITEMS[p]) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    op = OP_QUERY;
                else if (pick < 70)
                    op = OP_LABEL;
                else if (pick < 90)
                    op = OP_LINK;
                else
                    op = OP_NOP;
                queue_item(random_item(op));
                if (op != OP_NOP)
                    done_items++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dlrq_pkg.sv
rtl/core/dlrq_if.sv
rtl/core/dlrq_node_mem.sv
rtl/core/dlrq_link_mem.sv
rtl/core/dual_label_reachability_query.sv
test/dual_label_reachability_query_test.sv
